### rtl/core/cst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, codes and character helpers for the character stream
// tokenizer.
// ----------------------------------------------------------------------------
package cst_pkg;

	// Default width of the character offset counter
	localparam int POS_BITS_DEF = 16;

	// Output queue depth (power of two) and the room one character may need
	localparam int OQ_DEPTH = 8;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_FILL_W = $clog2(OQ_DEPTH + 1);
	localparam int MAX_TOK = 3;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam logic REG_FIRST_LINE = 1'b0;
	localparam logic [15:0] FIRST_LINE_RST = 16'd1;

	localparam logic [30:0] INT_MAX = 31'h7FFF_FFFF;
	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	// Characters with a meaning of their own
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	typedef enum logic [4:0] {
		K_END    = 5'd0,
		K_ERROR  = 5'd1,
		K_INT    = 5'd2,
		K_FLOAT  = 5'd3,
		K_STRING = 5'd4,
		K_IDENT  = 5'd5,
		K_LBRACK = 5'd6,
		K_RBRACK = 5'd7,
		K_LPAREN = 5'd8,
		K_RPAREN = 5'd9,
		K_LBRACE = 5'd10,
		K_RBRACE = 5'd11,
		K_LT     = 5'd12,
		K_GT     = 5'd13,
		K_EQ     = 5'd14,
		K_COMMA  = 5'd15,
		K_SEMI   = 5'd16,
		K_COLON  = 5'd17,
		K_PLUS   = 5'd18,
		K_MINUS  = 5'd19,
		K_STAR   = 5'd20,
		K_SLASH  = 5'd21,
		K_DOT    = 5'd22
	} kind_t;

	typedef enum logic [2:0] {
		M_IDLE    = 3'd0,
		M_NUM     = 3'd1,
		M_NUMDOT  = 3'd2,
		M_STR     = 3'd3,
		M_IDENT   = 3'd4,
		M_DISCARD = 3'd5
	} mode_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] len;
		logic [15:0] line;
		logic [30:0] ival;
		logic        ovf;
		logic        last;
	} tok_t;

	// Tokens produced by one character, in emission order from slot 0
	typedef struct packed {
		logic [1:0]         cnt;
		tok_t [MAX_TOK-1:0] tok;
	} lex_out_t;

	typedef struct packed {
		logic  hit;
		kind_t kind;
	} punct_t;

	typedef struct packed {
		logic        sat;
		logic [30:0] val;
	} acc_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_print(input logic [7:0] c);
		return (c >= CH_SPACE) && (c <= CH_TILDE);
	endfunction

	// Single-character punctuators
	function automatic punct_t punct_lookup(input logic [7:0] c);
		punct_t p;
		p.hit = 1'b1;
		case (c)
			8'h5B: p.kind = K_LBRACK; // [
			8'h5D: p.kind = K_RBRACK; // ]
			8'h28: p.kind = K_LPAREN; // (
			8'h29: p.kind = K_RPAREN; // )
			8'h7B: p.kind = K_LBRACE; // {
			8'h7D: p.kind = K_RBRACE; // }
			8'h3C: p.kind = K_LT;     // <
			8'h3E: p.kind = K_GT;     // >
			8'h3D: p.kind = K_EQ;     // =
			8'h2C: p.kind = K_COMMA;  // ,
			8'h3B: p.kind = K_SEMI;   // ;
			8'h3A: p.kind = K_COLON;  // :
			8'h2B: p.kind = K_PLUS;   // +
			8'h2D: p.kind = K_MINUS;  // -
			8'h2A: p.kind = K_STAR;   // *
			8'h2F: p.kind = K_SLASH;  // /
			8'h2E: p.kind = K_DOT;    // .
			default: begin
				p.hit = 1'b0;
				p.kind = K_ERROR;
			end
		endcase
		return p;
	endfunction

	// Saturating length add
	function automatic logic [15:0] len_add(input logic [15:0] len, input logic [1:0] k);
		logic [16:0] s;
		s = {1'b0, len} + {15'd0, k};
		return s[16] ? LEN_MAX : s[15:0];
	endfunction

	// accum * 10 + digit, saturating at 2^31-1
	function automatic acc_t acc_digit(input logic [30:0] acc, input logic [7:0] c);
		logic [34:0] v;
		acc_t r;
		v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {31'd0, c[3:0]};
		r.sat = (v > {4'd0, INT_MAX});
		r.val = r.sat ? INT_MAX : v[30:0];
		return r;
	endfunction

	function automatic tok_t make_tok(input kind_t kind, input logic [15:0] start,
		input logic [15:0] len, input logic [15:0] line, input logic [30:0] ival,
		input logic ovf);
		tok_t t;
		t.kind = kind;
		t.start = start;
		t.len = len;
		t.line = line;
		t.ival = ival;
		t.ovf = ovf;
		t.last = 1'b0;
		return t;
	endfunction

endpackage

### rtl/core/cst_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_lexer
// Scanner state and the combinational step: takes the registered character,
// produces up to three tokens and updates the scanner state on advance.
// ----------------------------------------------------------------------------
module cst_lexer #(
	parameter int POS_BITS = cst_pkg::POS_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [7:0]        ch_s1,
	input  logic [15:0]       first_line,
	output cst_pkg::lex_out_t lex
);
	import cst_pkg::*;

	mode_t               mode_q;
	logic [POS_BITS-1:0] offset_q;
	logic [15:0]         line_q;
	logic [15:0]         start_q;
	logic [15:0]         len_q;
	logic [30:0]         acc_q;
	logic                sat_q;
	logic                flt_q;

	mode_t               nxt_mode;
	logic [15:0]         nxt_line;
	logic [15:0]         nxt_start;
	logic [15:0]         nxt_len;
	logic [30:0]         nxt_acc;
	logic                nxt_sat;
	logic                nxt_flt;
	logic                restart;

	// Idle-mode handling of the character, computed once and used by the idle, number and identifier modes
	mode_t               id_mode;
	logic [15:0]         id_line;
	logic [15:0]         id_start;
	logic [15:0]         id_len;
	logic [30:0]         id_acc;
	logic                id_sat;
	logic                id_flt;
	logic                id_restart;
	logic                id_emit;
	tok_t                id_tok;

	logic [POS_BITS-1:0] off_p1;
	logic [POS_BITS-1:0] off_m1;
	logic [15:0]         off16;
	punct_t              pu;
	acc_t                dig;
	logic                c_dig;
	logic                c_ident;
	tok_t                flush_tok;

	assign off_p1 = offset_q + 1'b1;
	assign off_m1 = offset_q - 1'b1;
	assign off16 = 16'(offset_q);
	assign pu = punct_lookup(ch_s1);
	assign dig = acc_digit(acc_q, ch_s1);
	assign c_dig = is_digit(ch_s1);
	assign c_ident = is_alpha(ch_s1) || c_dig || (ch_s1 == CH_UNDER);

	// Pending number as a token
	always_comb begin
		if (flt_q) begin
			flush_tok = make_tok(K_FLOAT, start_q, len_q, line_q, '0, 1'b0);
		end else begin
			flush_tok = make_tok(K_INT, start_q, len_q, line_q, acc_q, sat_q);
		end
	end

	// Character seen with no token open
	always_comb begin
		id_mode = M_IDLE;
		id_line = line_q;
		id_start = start_q;
		id_len = len_q;
		id_acc = acc_q;
		id_sat = sat_q;
		id_flt = flt_q;
		id_restart = 1'b0;
		id_emit = 1'b0;
		id_tok = make_tok(K_ERROR, off16, 16'd1, line_q, '0, 1'b0);
		if (pu.hit) begin
			id_emit = 1'b1;
			id_tok = make_tok(pu.kind, off16, 16'd1, line_q, '0, 1'b0);
		end else if (c_dig) begin
			id_mode = M_NUM;
			id_start = off16;
			id_len = 16'd1;
			id_acc = {27'd0, ch_s1[3:0]};
			id_sat = 1'b0;
			id_flt = 1'b0;
		end else if (ch_s1 == CH_QUOTE) begin
			id_mode = M_STR;
			id_start = 16'(off_p1);
			id_len = 16'd0;
		end else if (is_alpha(ch_s1) || (ch_s1 == CH_UNDER)) begin
			id_mode = M_IDENT;
			id_start = off16;
			id_len = 16'd1;
		end else if (ch_s1 == CH_NUL) begin
			id_emit = 1'b1;
			id_tok = make_tok(K_END, off16, 16'd0, line_q, '0, 1'b0);
			id_line = first_line;
			id_restart = 1'b1;
		end else if (ch_s1 == CH_NL) begin
			id_line = line_q + 16'd1;
		end else if (is_print(ch_s1) && (ch_s1 != CH_SPACE)) begin
			id_emit = 1'b1;
			id_mode = M_DISCARD;
		end
	end

	// Step: per-mode handling, then the idle handler where the token closes
	always_comb begin
		logic use_idle;
		logic [1:0] n;
		use_idle = 1'b0;
		n = 2'd0;
		lex.tok = '0;
		nxt_mode = mode_q;
		nxt_line = line_q;
		nxt_start = start_q;
		nxt_len = len_q;
		nxt_acc = acc_q;
		nxt_sat = sat_q;
		nxt_flt = flt_q;
		restart = 1'b0;
		case (mode_q)
			M_NUM: begin
				if (c_dig) begin
					nxt_acc = dig.val;
					nxt_sat = sat_q | dig.sat;
					nxt_len = len_add(len_q, 2'd1);
				end else if (ch_s1 == CH_DOT) begin
					nxt_mode = M_NUMDOT;
				end else begin
					lex.tok[n] = flush_tok;
					n = n + 2'd1;
					use_idle = 1'b1;
				end
			end
			M_NUMDOT: begin
				if (c_dig) begin
					nxt_flt = 1'b1;
					nxt_acc = dig.val;
					nxt_sat = sat_q | dig.sat;
					nxt_len = len_add(len_q, 2'd2);
					nxt_mode = M_NUM;
				end else begin
					lex.tok[n] = flush_tok;
					n = n + 2'd1;
					lex.tok[n] = make_tok(K_DOT, 16'(off_m1), 16'd1, line_q, '0, 1'b0);
					n = n + 2'd1;
					use_idle = 1'b1;
				end
			end
			M_STR: begin
				if (ch_s1 == CH_QUOTE) begin
					lex.tok[n] = make_tok(K_STRING, start_q, len_q, line_q, '0, 1'b0);
					n = n + 2'd1;
					nxt_mode = M_IDLE;
				end else if (is_print(ch_s1)) begin
					nxt_len = len_add(len_q, 2'd1);
				end else begin
					// unprintable byte inside a string
					lex.tok[n] = make_tok(K_ERROR, off16, 16'd1, line_q, '0, 1'b0);
					n = n + 2'd1;
					nxt_mode = M_DISCARD;
					if (ch_s1 == CH_NUL) begin
						lex.tok[n] = make_tok(K_END, off16, 16'd0, line_q, '0, 1'b0);
						n = n + 2'd1;
						nxt_mode = M_IDLE;
						nxt_line = first_line;
						restart = 1'b1;
					end
				end
			end
			M_IDENT: begin
				if (c_ident) begin
					nxt_len = len_add(len_q, 2'd1);
				end else begin
					lex.tok[n] = make_tok(K_IDENT, start_q, len_q, line_q, '0, 1'b0);
					n = n + 2'd1;
					use_idle = 1'b1;
				end
			end
			M_DISCARD: begin
				if (ch_s1 == CH_NUL) begin
					lex.tok[n] = make_tok(K_END, off16, 16'd0, line_q, '0, 1'b0);
					n = n + 2'd1;
					nxt_mode = M_IDLE;
					nxt_line = first_line;
					restart = 1'b1;
				end
			end
			default: begin
				use_idle = 1'b1;
			end
		endcase
		if (use_idle) begin
			nxt_mode = id_mode;
			nxt_line = id_line;
			nxt_start = id_start;
			nxt_len = id_len;
			nxt_acc = id_acc;
			nxt_sat = id_sat;
			nxt_flt = id_flt;
			restart = id_restart;
			if (id_emit) begin
				lex.tok[n] = id_tok;
				n = n + 2'd1;
			end
		end
		if (n != 2'd0) begin
			lex.tok[n - 2'd1].last = 1'b1;
		end
		lex.cnt = n;
	end

	// Scanner control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			offset_q <= '0;
			line_q <= FIRST_LINE_RST;
			start_q <= '0;
			len_q <= '0;
			acc_q <= '0;
			sat_q <= 1'b0;
			flt_q <= 1'b0;
		end else if (adv) begin
			mode_q <= nxt_mode;
			offset_q <= restart ? '0 : off_p1;
			line_q <= nxt_line;
			start_q <= nxt_start;
			len_q <= nxt_len;
			acc_q <= nxt_acc;
			sat_q <= nxt_sat;
			flt_q <= nxt_flt;
		end
	end

endmodule

### rtl/core/cst_oq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_oq
// Output token queue: takes up to three tokens per cycle, hands out one
// per transaction from a register array.
// ----------------------------------------------------------------------------
module cst_oq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  cst_pkg::lex_out_t             lex,
	input  logic                          pop,
	output cst_pkg::tok_t                 head,
	output logic                          nonempty,
	output logic [cst_pkg::OQ_FILL_W-1:0] fill
);
	import cst_pkg::*;

	tok_t                 mem [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]  wr_q;
	logic [OQ_PTR_W-1:0]  rd_q;
	logic [OQ_FILL_W-1:0] fill_q;
	logic [1:0]           n_in;

	assign n_in = push ? lex.cnt : 2'd0;
	assign head = mem[rd_q];
	assign nonempty = (fill_q != '0);
	assign fill = fill_q;

	// Storage, up to three writes at consecutive slots
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_TOK; i++) begin
			if (2'(i) < n_in) begin
				mem[OQ_PTR_W'(wr_q + OQ_PTR_W'(i))] <= lex.tok[i];
			end
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			wr_q <= wr_q + OQ_PTR_W'(n_in);
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			fill_q <= fill_q + OQ_FILL_W'(n_in) - OQ_FILL_W'(pop);
		end
	end

endmodule

### rtl/core/char_stream_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_stream_tokenizer_top
// Lexical analyzer taking one character per transaction and delivering
// tokens one per transaction, with an APB-style register for first_line.
// ----------------------------------------------------------------------------
// Takes one character per clock cycle while ch_stall is low. A character is
// registered, then scanned once the output queue has room, which yields
// zero to three tokens; these are written into an 8-entry output queue,
// whose head drives the token outputs. ch_stall rises only while a
// character waits and the queue has fewer than three free entries, which
// with a consumer taking one token per cycle happens only after bursts of
// multi-token characters.
// first_line applies from the next NUL (end of text) onward.
module char_stream_tokenizer_top #(
	parameter int POS_BITS = cst_pkg::POS_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cst_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// character input
	input  logic                        ch_valid,
	output logic                        ch_stall,
	input  logic [7:0]                  ch,
	// token output
	output logic                        tok_valid,
	input  logic                        tok_stall,
	output logic [4:0]                  kind,
	output logic [15:0]                 start_res,
	output logic [15:0]                 length,
	output logic [15:0]                 line_no,
	output logic [30:0]                 int_value,
	output logic                        overflow,
	output logic                        last
);
	import cst_pkg::*;

	logic [15:0]          first_line_q;
	logic [7:0]           ch_s1;
	logic                 vld_s1;
	logic                 ch_acc;
	logic                 adv;
	logic                 room;
	lex_out_t             lex;
	tok_t                 head;
	logic [OQ_FILL_W-1:0] fill;
	logic                 pop;

	// Configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FIRST_LINE) ? {16'd0, first_line_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_line_q <= FIRST_LINE_RST;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FIRST_LINE)) begin
			first_line_q <= pwdata[15:0];
		end
	end

	// Input register; scan proceeds when the queue can take a full burst
	assign room = (fill <= OQ_FILL_W'(OQ_DEPTH - MAX_TOK));
	assign adv = vld_s1 && room;
	assign ch_stall = vld_s1 && !room;
	assign ch_acc = ch_valid && !ch_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ch_acc) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ch_acc) begin
			ch_s1 <= ch;
		end
	end

	cst_lexer #(
		.POS_BITS(POS_BITS)
	) u_lexer (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.ch_s1      (ch_s1),
		.first_line (first_line_q),
		.lex        (lex)
	);

	// Output queue
	assign pop = tok_valid && !tok_stall;

	cst_oq u_oq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (adv),
		.lex      (lex),
		.pop      (pop),
		.head     (head),
		.nonempty (tok_valid),
		.fill     (fill)
	);

	assign kind = head.kind;
	assign start_res = head.start;
	assign length = head.len;
	assign line_no = head.line;
	assign int_value = head.ival;
	assign overflow = head.ovf;
	assign last = head.last;

	// Checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= OQ_FILL_W'(OQ_DEPTH))
		else $error("output queue overfilled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		ch_stall |-> (vld_s1 && (fill > OQ_FILL_W'(OQ_DEPTH - MAX_TOK))))
		else $error("input stalled without a waiting character");

	a_accept_held: assert property (@(posedge clk) disable iff (!arst_n)
		ch_acc |=> vld_s1)
		else $error("accepted character lost");

	a_burst_fits: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> (fill + OQ_FILL_W'(lex.cnt) <= OQ_FILL_W'(OQ_DEPTH)))
		else $error("token burst exceeds queue space");

endmodule
